[rtl/core/mandelbrot_escape_time_pixel_macros.svh]
// ----------------------------------------------------------------------------
// mandelbrot escape-time pixel assertion macros
// Concurrent check wrappers; they expand to nothing in synthesis.
// ----------------------------------------------------------------------------
`ifndef MANDELBROT_ESCAPE_TIME_PIXEL_MACROS_SVH
`define MANDELBROT_ESCAPE_TIME_PIXEL_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication, checked out of reset
`define MBROT_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("mbrot check failed");
// next-cycle implication, checked out of reset
`define MBROT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("mbrot check failed");
`else
`define MBROT_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define MBROT_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

[rtl/core/mbrot_pkg.sv]
// ----------------------------------------------------------------------------
// mbrot_pkg
// Shared types, fixed-point constants and the color palette.
// ----------------------------------------------------------------------------
package mbrot_pkg;

	// fixed-point format
	localparam int FRAC_W    = 28;
	localparam int ORIGIN_W  = 32;
	localparam int STEP_W    = 31;
	localparam int LIMIT_W   = 16;
	localparam int ZMUL_W    = 30;
	localparam int SQ_W      = 31;
	localparam int CFG_W     = 32;
	localparam int CFG_IDX_W = 3;
	localparam int COLOR_W   = 8;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_REAL_ORIGIN = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAG_ORIGIN = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_REAL_STEP   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_IMAG_STEP   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_LIMIT       = 3'd4;

	// register reset values
	localparam logic signed [ORIGIN_W-1:0] RST_REAL_ORIGIN = 32'shD8000000;
	localparam logic signed [ORIGIN_W-1:0] RST_IMAG_ORIGIN = 32'shE0000000;
	localparam logic [STEP_W-1:0]          RST_REAL_STEP   = 31'd65536;
	localparam logic [STEP_W-1:0]          RST_IMAG_STEP   = 31'd65536;
	localparam logic [LIMIT_W-1:0]         RST_LIMIT       = 16'd200;

	typedef struct packed {
		logic signed [ORIGIN_W-1:0] real_origin;
		logic signed [ORIGIN_W-1:0] imag_origin;
		logic [STEP_W-1:0]          real_step;
		logic [STEP_W-1:0]          imag_step;
		logic [LIMIT_W-1:0]         limit;
	} cfg_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic map;
		logic snap;
		logic step;
		logic finish;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic finish;
	} status_t;

	typedef struct packed {
		logic [COLOR_W-1:0] r;
		logic [COLOR_W-1:0] g;
		logic [COLOR_W-1:0] b;
	} rgb_t;

	localparam rgb_t INSIDE_RGB = '{r: 8'd16, g: 8'd16, b: 8'd16};

	// sixteen-entry escape palette
	function automatic rgb_t palette(input logic [3:0] idx);
		rgb_t c;
		case (idx)
			4'd0:    c = '{r: 8'd66,  g: 8'd30,  b: 8'd15};
			4'd1:    c = '{r: 8'd25,  g: 8'd7,   b: 8'd26};
			4'd2:    c = '{r: 8'd9,   g: 8'd1,   b: 8'd47};
			4'd3:    c = '{r: 8'd4,   g: 8'd4,   b: 8'd73};
			4'd4:    c = '{r: 8'd0,   g: 8'd7,   b: 8'd100};
			4'd5:    c = '{r: 8'd12,  g: 8'd44,  b: 8'd138};
			4'd6:    c = '{r: 8'd24,  g: 8'd82,  b: 8'd177};
			4'd7:    c = '{r: 8'd57,  g: 8'd125, b: 8'd209};
			4'd8:    c = '{r: 8'd134, g: 8'd181, b: 8'd229};
			4'd9:    c = '{r: 8'd211, g: 8'd236, b: 8'd248};
			4'd10:   c = '{r: 8'd241, g: 8'd233, b: 8'd191};
			4'd11:   c = '{r: 8'd248, g: 8'd201, b: 8'd95};
			4'd12:   c = '{r: 8'd255, g: 8'd170, b: 8'd0};
			4'd13:   c = '{r: 8'd204, g: 8'd128, b: 8'd0};
			4'd14:   c = '{r: 8'd153, g: 8'd87,  b: 8'd0};
			default: c = '{r: 8'd106, g: 8'd52,  b: 8'd3};
		endcase
		return c;
	endfunction

endpackage

[rtl/core/mandelbrot_escape_time_pixel.sv]
// ----------------------------------------------------------------------------
// mandelbrot_escape_time_pixel
// Escape-time Mandelbrot pixel with a sixteen-entry color palette.
// ----------------------------------------------------------------------------
// A pixel is taken on a clock edge with start high and busy low. It maps the
// pixel to c, then updates z once per cycle in the datapath's single
// iteration unit: it maps, snaps, iterates until the exit is seen (the
// iteration that sees the exit does not update z) and then puts the result
// on the ports. The result stands for exactly one cycle with done high and
// cannot be held off; capture it then. The next start is taken in that same
// cycle. Configuration writes belong to idle.
module mandelbrot_escape_time_pixel #(
	parameter int MAX_DIM = 16384
) (
	input  logic                                                  clk,
	input  logic                                                  arst_n,
	input  logic                                                  start,
	output logic                                                  busy,
	output logic                                                  done,
	input  logic [((MAX_DIM > 1) ? $clog2(MAX_DIM) : 1)-1:0]      column,
	input  logic [((MAX_DIM > 1) ? $clog2(MAX_DIM) : 1)-1:0]      row,
	output logic [((MAX_DIM > 1) ? $clog2(MAX_DIM) : 1)-1:0]      out_column,
	output logic [((MAX_DIM > 1) ? $clog2(MAX_DIM) : 1)-1:0]      out_row,
	output logic [mbrot_pkg::LIMIT_W-1:0]                         escape_count,
	output logic [mbrot_pkg::COLOR_W-1:0]                         red,
	output logic [mbrot_pkg::COLOR_W-1:0]                         green,
	output logic [mbrot_pkg::COLOR_W-1:0]                         blue,
	input  logic                                                  cfg_write,
	input  logic [mbrot_pkg::CFG_IDX_W-1:0]                       cfg_index,
	input  logic [mbrot_pkg::CFG_W-1:0]                           cfg_data
);
	import mbrot_pkg::*;

	`include "mandelbrot_escape_time_pixel_macros.svh"

	localparam int COORD_W = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;

	cfg_t    cfg;
	cmd_t    cmd;
	status_t stat;
	rgb_t    color;

	// configuration registers
	mbrot_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// sequencer
	mbrot_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	// arithmetic
	mbrot_dp #(
		.COORD_W (COORD_W)
	) u_dp (
		.clk          (clk),
		.cmd          (cmd),
		.cfg          (cfg),
		.column       (column),
		.row          (row),
		.stat         (stat),
		.out_column   (out_column),
		.out_row      (out_row),
		.escape_count (escape_count),
		.color        (color)
	);

	assign red   = color.r;
	assign green = color.g;
	assign blue  = color.b;

	// checks
	`MBROT_ASSERT_NEXT(a_done_single, clk, arst_n, done, !done)
	`MBROT_ASSERT_NEXT(a_start_busy, clk, arst_n, start && !busy, busy && !done)
	`MBROT_ASSERT_SAME(a_done_idle, clk, arst_n, done, !busy)
	`MBROT_ASSERT_SAME(a_count_limit, clk, arst_n, done, escape_count <= cfg.limit)

endmodule

[rtl/core/mbrot_regs.sv]
// ----------------------------------------------------------------------------
// mbrot_regs
// Configuration register file with a plain write port; unknown indexes drop.
// ----------------------------------------------------------------------------
module mbrot_regs (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_write,
	input  logic [mbrot_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [mbrot_pkg::CFG_W-1:0]          cfg_data,
	output mbrot_pkg::cfg_t                      cfg
);
	import mbrot_pkg::*;

	cfg_t cfg_q;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.real_origin <= RST_REAL_ORIGIN;
			cfg_q.imag_origin <= RST_IMAG_ORIGIN;
			cfg_q.real_step   <= RST_REAL_STEP;
			cfg_q.imag_step   <= RST_IMAG_STEP;
			cfg_q.limit       <= RST_LIMIT;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_REAL_ORIGIN: cfg_q.real_origin <= $signed(cfg_data);
				REG_IMAG_ORIGIN: cfg_q.imag_origin <= $signed(cfg_data);
				REG_REAL_STEP:   cfg_q.real_step   <= cfg_data[STEP_W-1:0];
				REG_IMAG_STEP:   cfg_q.imag_step   <= cfg_data[STEP_W-1:0];
				REG_LIMIT:       cfg_q.limit       <= cfg_data[LIMIT_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

[rtl/core/mbrot_ctrl.sv]
// ----------------------------------------------------------------------------
// mbrot_ctrl
// Sequencer: load, map to c, snap the imaginary part, iterate, deliver.
// ----------------------------------------------------------------------------
module mbrot_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  mbrot_pkg::status_t   stat,
	output mbrot_pkg::cmd_t      cmd,
	output logic                 busy,
	output logic                 done
);
	import mbrot_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MAP,
		ST_SNAP,
		ST_ITER
	} state_t;

	state_t state_q;
	logic   done_q;

	// state and result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (start) state_q <= ST_MAP;
				end
				ST_MAP:  state_q <= ST_SNAP;
				ST_SNAP: state_q <= ST_ITER;
				ST_ITER: begin
					if (stat.finish) begin
						state_q <= ST_IDLE;
						done_q  <= 1'b1;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath commands
	always_comb begin
		cmd        = '0;
		cmd.load   = (state_q == ST_IDLE) && start;
		cmd.map    = (state_q == ST_MAP);
		cmd.snap   = (state_q == ST_SNAP);
		cmd.step   = (state_q == ST_ITER) && !stat.finish;
		cmd.finish = (state_q == ST_ITER) && stat.finish;
	end

	assign busy = (state_q != ST_IDLE);
	assign done = done_q;

endmodule

[rtl/core/mbrot_dp.sv]
// ----------------------------------------------------------------------------
// mbrot_dp
// Point mapping, snap and the z = z^2 + c update, one iteration per cycle.
// ----------------------------------------------------------------------------
module mbrot_dp #(
	parameter int COORD_W = 14
) (
	input  logic                              clk,
	input  mbrot_pkg::cmd_t                   cmd,
	input  mbrot_pkg::cfg_t                   cfg,
	input  logic [COORD_W-1:0]                column,
	input  logic [COORD_W-1:0]                row,
	output mbrot_pkg::status_t                stat,
	output logic [COORD_W-1:0]                out_column,
	output logic [COORD_W-1:0]                out_row,
	output logic [mbrot_pkg::LIMIT_W-1:0]     escape_count,
	output mbrot_pkg::rgb_t                   color
);
	import mbrot_pkg::*;

	// c and z width: origin plus largest index times step, with headroom
	localparam int PW = COORD_W + STEP_W;
	localparam int CW = PW + 2;
	localparam int MW = 2 * ZMUL_W;
	localparam logic signed [CW-1:0] TWO_POS = CW'(2 ** (FRAC_W + 1));
	localparam logic signed [CW-1:0] TWO_NEG = -TWO_POS;
	localparam logic [SQ_W-1:0]      FOUR_SQ = SQ_W'(2 ** (FRAC_W + 2));
	localparam logic [SQ_W:0]        FOUR_SUM = (SQ_W + 1)'(2 ** (FRAC_W + 2));

	logic [COORD_W-1:0]       col_q, row_q;
	logic signed [CW-1:0]     cx_q, cy_q, zx_q, zy_q;
	logic [LIMIT_W-1:0]       cnt_q;
	logic [COORD_W-1:0]       out_col_q, out_row_q;
	logic [LIMIT_W-1:0]       out_cnt_q;
	rgb_t                     out_rgb_q;

	logic [PW-1:0]            col_prod, row_prod;
	logic signed [CW-1:0]     cx_map, cy_map;
	logic [CW-1:0]            cy_abs;
	logic                     snap_zero;
	logic signed [ZMUL_W-1:0] zx_m, zy_m;
	logic signed [MW-1:0]     pxx, pyy, pxy;
	logic                     big_x, big_y;
	logic [SQ_W-1:0]          sq_x, sq_y;
	logic                     escaped, at_limit;
	logic signed [CW-1:0]     nx, ny;

	// c = origin + index * step
	assign col_prod = PW'(col_q) * PW'(cfg.real_step);
	assign row_prod = PW'(row_q) * PW'(cfg.imag_step);
	assign cx_map   = CW'(cfg.real_origin) + CW'($signed({1'b0, col_prod}));
	assign cy_map   = CW'(cfg.imag_origin) + CW'($signed({1'b0, row_prod}));

	// imaginary part under half a pixel height goes to zero
	assign cy_abs    = cy_q[CW-1] ? CW'(-cy_q) : CW'(cy_q);
	assign snap_zero = {cy_abs, 1'b0} < (CW + 1)'(cfg.imag_step);

	// products of the current z; a component of 2.0 or more squares to 4.0
	assign zx_m  = zx_q[ZMUL_W-1:0];
	assign zy_m  = zy_q[ZMUL_W-1:0];
	assign pxx   = MW'(zx_m) * MW'(zx_m);
	assign pyy   = MW'(zy_m) * MW'(zy_m);
	assign pxy   = MW'(zx_m) * MW'(zy_m);
	assign big_x = (zx_q >= TWO_POS) || (zx_q <= TWO_NEG);
	assign big_y = (zy_q >= TWO_POS) || (zy_q <= TWO_NEG);
	assign sq_x  = big_x ? FOUR_SQ : pxx[FRAC_W+SQ_W-1:FRAC_W];
	assign sq_y  = big_y ? FOUR_SQ : pyy[FRAC_W+SQ_W-1:FRAC_W];

	// loop exit
	assign escaped     = ({1'b0, sq_x} + {1'b0, sq_y}) >= FOUR_SUM;
	assign at_limit    = (cnt_q == cfg.limit);
	assign stat.finish = escaped || at_limit;

	// next z: cross term is a floor shift by one less than the fraction
	assign nx = cx_q + CW'($signed({1'b0, sq_x})) - CW'($signed({1'b0, sq_y}));
	assign ny = CW'($signed(pxy[MW-1:FRAC_W-1])) + cy_q;

	// working registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			col_q <= column;
			row_q <= row;
		end
		if (cmd.map) begin
			cx_q <= cx_map;
			cy_q <= cy_map;
		end
		if (cmd.snap) begin
			if (snap_zero) cy_q <= '0;
			zx_q  <= '0;
			zy_q  <= '0;
			cnt_q <= '0;
		end
		if (cmd.step) begin
			zx_q  <= nx;
			zy_q  <= ny;
			cnt_q <= cnt_q + LIMIT_W'(1);
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			out_col_q <= col_q;
			out_row_q <= row_q;
			out_cnt_q <= cnt_q;
			out_rgb_q <= at_limit ? INSIDE_RGB : palette(cnt_q[3:0]);
		end
	end

	assign out_column   = out_col_q;
	assign out_row      = out_row_q;
	assign escape_count = out_cnt_q;
	assign color        = out_rgb_q;

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mandelbrot escape-time pixel testbench
// Feeds pixel coordinates through the start/busy port under changing views and
// iteration limits, predicts each escape count and palette color in Q.28 fixed
// point, and checks every done strobe against the oldest pending prediction.
// ----------------------------------------------------------------------------
module testbench;
	import mbrot_pkg::*;

	localparam int MAX_DIM = 16384;
	localparam int COORD_W = $clog2(MAX_DIM);
	localparam int CYCLE_LIMIT = 20000000;
	localparam int SETTLE_CYCLES = 8;
	localparam int RANDOM_PIXELS = 1100;
	localparam int PALETTE_N = 16;
	localparam longint TWO_RAW = 64'sd1 << 29;
	localparam longint FOUR_RAW = 64'sd1 << 30;

	localparam rgb_t SHADES [PALETTE_N] = '{
		'{8'd66, 8'd30, 8'd15}, '{8'd25, 8'd7, 8'd26}, '{8'd9, 8'd1, 8'd47},
		'{8'd4, 8'd4, 8'd73}, '{8'd0, 8'd7, 8'd100}, '{8'd12, 8'd44, 8'd138},
		'{8'd24, 8'd82, 8'd177}, '{8'd57, 8'd125, 8'd209}, '{8'd134, 8'd181, 8'd229},
		'{8'd211, 8'd236, 8'd248}, '{8'd241, 8'd233, 8'd191}, '{8'd248, 8'd201, 8'd95},
		'{8'd255, 8'd170, 8'd0}, '{8'd204, 8'd128, 8'd0}, '{8'd153, 8'd87, 8'd0},
		'{8'd106, 8'd52, 8'd3}
	};

	typedef struct packed {
		logic [COORD_W-1:0] col;
		logic [COORD_W-1:0] row;
	} pixel_req_t;

	typedef struct packed {
		logic [COORD_W-1:0] col;
		logic [COORD_W-1:0] row;
		logic [LIMIT_W-1:0] count;
		rgb_t               shade;
	} pixel_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic done;
	logic [COORD_W-1:0] column = '0;
	logic [COORD_W-1:0] row = '0;
	logic [COORD_W-1:0] out_column;
	logic [COORD_W-1:0] out_row;
	logic [LIMIT_W-1:0] escape_count;
	logic [COLOR_W-1:0] red;
	logic [COLOR_W-1:0] green;
	logic [COLOR_W-1:0] blue;
	logic cfg_write = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0] cfg_data = '0;

	// view and limit as the block should hold them
	logic signed [ORIGIN_W-1:0] re_origin = RST_REAL_ORIGIN;
	logic signed [ORIGIN_W-1:0] im_origin = RST_IMAG_ORIGIN;
	logic [STEP_W-1:0] re_step = RST_REAL_STEP;
	logic [STEP_W-1:0] im_step = RST_IMAG_STEP;
	logic [LIMIT_W-1:0] iter_limit = RST_LIMIT;

	pixel_req_t pixel_q[$];
	pixel_t pixels_due[$];
	int errors = 0;
	int cycle_count = 0;
	int pause_left;
	logic burst = 1'b0;

	mandelbrot_escape_time_pixel #(
		.MAX_DIM(MAX_DIM)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.done(done),
		.column(column),
		.row(row),
		.out_column(out_column),
		.out_row(out_row),
		.escape_count(escape_count),
		.red(red),
		.green(green),
		.blue(blue),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// square clamped to 4.0 once a component reaches 2.0
	function automatic longint square_clamped(input longint a);
		longint mag;
		mag = (a < 0) ? -a : a;
		if (mag >= TWO_RAW)
			return FOUR_RAW;
		return (a * a) >>> FRAC_W;
	endfunction

	// escape count and color of one pixel under the current view
	function automatic pixel_t escape_pixel(input logic [COORD_W-1:0] col,
			input logic [COORD_W-1:0] rw);
		longint cx, cy, cy_mag, zx, zy, zx_sq, zy_sq, nx, ny;
		int count;
		pixel_t res;
		cx = longint'(re_origin) + longint'(col) * longint'(re_step);
		cy = longint'(im_origin) + longint'(rw) * longint'(im_step);
		// snap to the real axis within half a row
		cy_mag = (cy < 0) ? -cy : cy;
		if (cy_mag * 2 < longint'(im_step))
			cy = 0;
		zx = 0;
		zy = 0;
		zx_sq = 0;
		zy_sq = 0;
		count = 0;
		while (count < int'(iter_limit) && zx_sq + zy_sq < FOUR_RAW) begin
			ny = ((zx * zy) >>> (FRAC_W - 1)) + cy;
			nx = zx_sq - zy_sq + cx;
			zx = nx;
			zy = ny;
			zx_sq = square_clamped(zx);
			zy_sq = square_clamped(zy);
			count++;
		end
		res.col = col;
		res.row = rw;
		res.count = LIMIT_W'(count);
		res.shade = (count == int'(iter_limit)) ? INSIDE_RGB : SHADES[count % PALETTE_N];
		return res;
	endfunction

	// pixel feeder: predicts on each start transfer, then loads the next pixel
	always @(posedge clk or negedge arst_n) begin
		pixel_req_t nxt;
		if (!arst_n) begin
			start <= 1'b0;
			column <= '0;
			row <= '0;
			pause_left <= 0;
			burst <= 1'b0;
		end else begin
			if (start && !busy)
				pixels_due.push_back(escape_pixel(column, row));
			if (!start || !busy) begin
				if (pause_left != 0) begin
					start <= 1'b0;
					pause_left <= pause_left - 1;
				end else if (pixel_q.size() != 0) begin
					nxt = pixel_q.pop_front();
					column <= nxt.col;
					row <= nxt.row;
					start <= 1'b1;
					pause_left <= burst ? 0 : int'($urandom_range(0, 11));
					if ($urandom_range(0, 31) == 0)
						burst <= ~burst;
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	task automatic compare_field(input string field, input int want, input int got);
		if (want != got) begin
			$display("%0t ns: %s expected %0d, got %0d", $time, field, want, got);
			errors++;
		end
	endtask

	// result checker: each done strobe is one transfer
	always @(posedge clk) begin
		pixel_t got;
		pixel_t want;
		if (arst_n && done) begin
			got = {out_column, out_row, escape_count, red, green, blue};
			if (pixels_due.size() == 0) begin
				$display("%0t ns: result with none pending, got column %0d row %0d count %0d",
					$time, got.col, got.row, got.count);
				errors++;
			end else begin
				want = pixels_due.pop_front();
				compare_field("out_column", want.col, got.col);
				compare_field("out_row", want.row, got.row);
				compare_field("escape_count", want.count, got.count);
				compare_field("red", want.shade.r, got.shade.r);
				compare_field("green", want.shade.g, got.shade.g);
				compare_field("blue", want.shade.b, got.shade.b);
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
		@(posedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		case (idx)
			REG_REAL_ORIGIN: re_origin = data;
			REG_IMAG_ORIGIN: im_origin = data;
			REG_REAL_STEP: re_step = data[STEP_W-1:0];
			REG_IMAG_STEP: im_step = data[STEP_W-1:0];
			REG_LIMIT: iter_limit = data[LIMIT_W-1:0];
			default: ;
		endcase
	endtask

	task automatic finish_writes();
		@(posedge clk);
		cfg_write <= 1'b0;
		@(negedge clk);
	endtask

	task automatic queue_pixel(input int col, input int rw);
		pixel_req_t req;
		req.col = COORD_W'(col);
		req.row = COORD_W'(rw);
		pixel_q.push_back(req);
	endtask

	// sender holds off until every pending result is back
	task automatic wait_idle();
		do
			@(negedge clk);
		while (pixel_q.size() != 0 || start || pixels_due.size() != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	initial begin
		int kind;
		int n;
		int random_issued;
		logic [LIMIT_W-1:0] lim;

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		repeat (2) @(negedge clk);

		// reset view: corners, real-axis interior, exactly -2.0, a slow escape
		queue_pixel(0, 0);
		queue_pixel(MAX_DIM - 1, MAX_DIM - 1);
		queue_pixel(MAX_DIM - 1, 0);
		queue_pixel(0, MAX_DIM - 1);
		queue_pixel(6144, 8192);
		queue_pixel(10240, 8192);
		queue_pixel(2048, 8192);
		queue_pixel(12288, 8192);
		queue_pixel(8000, 10000);
		wait_idle();

		// zero limit gives the interior color; unused index is ignored
		write_reg(REG_LIMIT, 32'hABCD_0000);
		write_reg(REG_LIMIT + 3'd1, 32'hFFFF_FFFF);
		finish_writes();
		queue_pixel(5, 5);
		queue_pixel(MAX_DIM - 1, 0);
		wait_idle();

		// extreme origins and steps: large z clamps and escapes at once
		write_reg(REG_REAL_ORIGIN, 32'h8000_0000);
		write_reg(REG_IMAG_ORIGIN, 32'h7FFF_FFFF);
		write_reg(REG_REAL_STEP, 32'hFFFF_FFFF);
		write_reg(REG_IMAG_STEP, 32'hFFFF_FFFF);
		write_reg(REG_LIMIT, 32'hFFFF_FFFF);
		finish_writes();
		queue_pixel(0, 0);
		queue_pixel(MAX_DIM - 1, MAX_DIM - 1);
		queue_pixel(0, MAX_DIM - 1);
		wait_idle();
		write_reg(REG_REAL_ORIGIN, 32'h7FFF_FFFF);
		write_reg(REG_IMAG_ORIGIN, 32'h8000_0000);
		finish_writes();
		queue_pixel(0, 0);
		queue_pixel(MAX_DIM - 1, 0);
		wait_idle();

		// c = 0 runs to the full 16-bit limit
		write_reg(REG_REAL_ORIGIN, '0);
		write_reg(REG_IMAG_ORIGIN, '0);
		write_reg(REG_REAL_STEP, 32'h8000_0000);
		write_reg(REG_IMAG_STEP, 32'h8000_0000);
		finish_writes();
		queue_pixel(0, 0);
		queue_pixel(MAX_DIM - 1, MAX_DIM - 1);
		wait_idle();

		// limit of one
		write_reg(REG_REAL_ORIGIN, CFG_W'(-(1 << 27)));
		write_reg(REG_LIMIT, 32'h0001_0001);
		finish_writes();
		queue_pixel(3, 9);
		wait_idle();

		// half-row snap near c = -0.75, where snapping keeps the point inside
		write_reg(REG_REAL_ORIGIN, CFG_W'(-(3 << 26)));
		write_reg(REG_IMAG_STEP, CFG_W'(1 << 22));
		write_reg(REG_IMAG_ORIGIN, CFG_W'(-(1 << 21) + 1));
		write_reg(REG_LIMIT, 32'd1000);
		finish_writes();
		queue_pixel(0, 0);
		queue_pixel(0, 1);
		wait_idle();
		write_reg(REG_IMAG_ORIGIN, CFG_W'(-(1 << 21)));
		finish_writes();
		queue_pixel(0, 0);
		wait_idle();
		write_reg(REG_IMAG_ORIGIN, CFG_W'((1 << 21) - 1));
		finish_writes();
		queue_pixel(MAX_DIM - 1, 0);
		wait_idle();

		// random views and limits, one batch per setting
		random_issued = 0;
		while (random_issued < RANDOM_PIXELS) begin
			kind = $urandom_range(0, 15);
			if (kind < 11) begin
				if ($urandom_range(0, 3) != 0)
					write_reg(REG_REAL_ORIGIN,
						CFG_W'($urandom_range(0, 3 << 28)) - CFG_W'(5 << 27));
				if ($urandom_range(0, 3) != 0)
					write_reg(REG_IMAG_ORIGIN,
						CFG_W'($urandom_range(0, 2 << 28)) - CFG_W'(3 << 27));
				if ($urandom_range(0, 3) != 0)
					write_reg(REG_REAL_STEP, {1'($urandom_range(0, 1)),
						31'($urandom_range(1 << 8, 1 << 16))});
				if ($urandom_range(0, 3) != 0)
					write_reg(REG_IMAG_STEP, {1'($urandom_range(0, 1)),
						31'($urandom_range(1 << 8, 1 << 16))});
			end else if (kind < 14) begin
				write_reg(REG_REAL_ORIGIN, CFG_W'($urandom()));
				write_reg(REG_IMAG_ORIGIN, CFG_W'($urandom()));
				write_reg(REG_REAL_STEP, CFG_W'($urandom()));
				write_reg(REG_IMAG_STEP, CFG_W'($urandom()));
			end else begin
				// near-zero steps pile every pixel onto one point
				write_reg(REG_REAL_ORIGIN,
					CFG_W'($urandom_range(0, 3 << 28)) - CFG_W'(5 << 27));
				write_reg(REG_IMAG_ORIGIN,
					CFG_W'($urandom_range(0, 2 << 28)) - CFG_W'(3 << 27));
				write_reg(REG_REAL_STEP, {1'($urandom_range(0, 1)),
					31'($urandom_range(0, 3))});
				write_reg(REG_IMAG_STEP, {1'($urandom_range(0, 1)),
					31'($urandom_range(0, 3))});
			end
			if ($urandom_range(0, 3) != 0) begin
				case ($urandom_range(0, 31))
					0: lim = '0;
					1: lim = 16'd1;
					2: lim = LIMIT_W'($urandom_range(1000, 3000));
					default: lim = LIMIT_W'($urandom_range(2, 255));
				endcase
				write_reg(REG_LIMIT, {16'($urandom()), lim});
			end
			if ($urandom_range(0, 7) == 0)
				write_reg(REG_LIMIT + 3'($urandom_range(1, 3)), CFG_W'($urandom()));
			finish_writes();

			n = (iter_limit > 512) ? $urandom_range(2, 6) : $urandom_range(8, 48);
			repeat (n)
				queue_pixel($urandom_range(0, MAX_DIM - 1), $urandom_range(0, MAX_DIM - 1));
			random_issued += n;
			wait_idle();
		end

		if (errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
